// ===== rtl/btb_pkg.sv =====
package btb_pkg;

    // Fixed geometry
    localparam int ROWS      = 32;
    localparam int ROW_W     = 5;
    localparam int HIST_W    = 8;
    localparam int TAG_W     = 30;
    localparam int SLOT_W    = ROW_W + HIST_W;       // counter slot index
    localparam int LANES     = 8;                    // counters per memory word
    localparam int LANE_W    = 3;
    localparam int WORD_W    = 2 * LANES;
    localparam int MADDR_W   = SLOT_W - LANE_W;      // memory word address
    localparam int MDEPTH    = 1 << MADDR_W;
    localparam int ROW_WORDS = (1 << HIST_W) / LANES; // words per row table
    localparam int RWORD_W   = HIST_W - LANE_W;

    // Configuration register indexes
    localparam logic [2:0] REG_ROWS_LOG2      = 3'd0;
    localparam logic [2:0] REG_HISTORY_BITS   = 3'd1;
    localparam logic [2:0] REG_TAG_BITS       = 3'd2;
    localparam logic [2:0] REG_COUNTER_INIT   = 3'd3;
    localparam logic [2:0] REG_GLOBAL_HISTORY = 3'd4;
    localparam logic [2:0] REG_GLOBAL_TABLE   = 3'd5;
    localparam logic [2:0] REG_SHARE_MODE     = 3'd6;

    // Commands and share modes
    localparam logic       CMD_PREDICT  = 1'b0;
    localparam logic       CMD_UPDATE   = 1'b1;
    localparam logic [1:0] SHARE_NONE   = 2'd0;
    localparam logic [1:0] SHARE_LOW    = 2'd1;
    localparam logic [1:0] SHARE_HIGH   = 2'd2;

    localparam logic [1:0] COUNTER_RESET = 2'd1;

    typedef struct packed {
        logic        command;
        logic [31:0] pc;
        logic [31:0] target_pc;
        logic        taken;
        logic [31:0] predicted_target;
    } t_in_word;

    typedef struct packed {
        logic        predict_taken;
        logic [31:0] next_pc;
        logic        flush;
        logic [31:0] branch_count;
        logic [31:0] flush_count;
        logic        misaligned;
    } t_out_word;

    typedef struct packed {
        logic               load;     // capture input word
        logic               mem_rd;   // read counter word for slot
        logic               alloc;    // allocate row
        logic               init_wr;  // reset sweep write
        logic               clr_wr;   // row table clear write
        logic [MADDR_W-1:0] sweep;    // sweep index
        logic               finish;   // apply update, register result
    } t_ctl_cmd;

    typedef struct packed {
        logic misaligned;
        logic is_update;
        logic hit;
        logic local_table;
        logic out_free;
    } t_ctl_stat;

endpackage

// ===== rtl/btb_ctrl.sv =====
module btb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  btb_pkg::t_ctl_stat  i_stat,
    output btb_pkg::t_ctl_cmd   o_cmd,
    output logic                o_idle
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLR,
        S_MOD
    } t_state;

    t_state                      r_state, n_state;
    logic [btb_pkg::MADDR_W-1:0] r_sweep, n_sweep;

    // Next state
    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        case (r_state)
            S_INIT: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == btb_pkg::MADDR_W'(btb_pkg::MDEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_sweep = '0;
                if (!i_stat.misaligned && i_stat.is_update && !i_stat.hit) begin
                    n_state = i_stat.local_table ? S_CLR : S_READ;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_CLR: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == btb_pkg::MADDR_W'(btb_pkg::ROW_WORDS - 1)) begin
                    n_state = S_READ;
                end
            end
            S_MOD: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
        end
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.sweep   = r_sweep;
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.init_wr = (r_state == S_INIT);
        o_cmd.clr_wr  = (r_state == S_CLR);
        o_cmd.finish  = (r_state == S_MOD) && i_stat.out_free;
        if (r_state == S_READ) begin
            if (!i_stat.misaligned && i_stat.is_update && !i_stat.hit) begin
                o_cmd.alloc = 1'b1;
            end else begin
                o_cmd.mem_rd = 1'b1;
            end
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ===== rtl/btb_datapath.sv =====
module btb_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btb_pkg::t_ctl_cmd   i_cmd,
    output btb_pkg::t_ctl_stat  o_stat,
    input  btb_pkg::t_in_word   i_in_word,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output btb_pkg::t_out_word  o_out_word
);

    // Configuration registers
    logic [2:0] r_rows_log2;
    logic [3:0] r_history_bits;
    logic [4:0] r_tag_bits;
    logic [1:0] r_counter_init;
    logic       r_global_history;
    logic       r_global_table;
    logic [1:0] r_share_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_log2      <= 3'd5;
            r_history_bits   <= 4'd2;
            r_tag_bits       <= 5'd0;
            r_counter_init   <= btb_pkg::COUNTER_RESET;
            r_global_history <= 1'b0;
            r_global_table   <= 1'b0;
            r_share_mode     <= btb_pkg::SHARE_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                btb_pkg::REG_ROWS_LOG2:      r_rows_log2      <= i_cfg_data[2:0];
                btb_pkg::REG_HISTORY_BITS:   r_history_bits   <= i_cfg_data[3:0];
                btb_pkg::REG_TAG_BITS:       r_tag_bits       <= i_cfg_data[4:0];
                btb_pkg::REG_COUNTER_INIT:   r_counter_init   <= i_cfg_data[1:0];
                btb_pkg::REG_GLOBAL_HISTORY: r_global_history <= i_cfg_data[0];
                btb_pkg::REG_GLOBAL_TABLE:   r_global_table   <= i_cfg_data[0];
                btb_pkg::REG_SHARE_MODE:     r_share_mode     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Captured word
    btb_pkg::t_in_word r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_word;
        end
    end

    // Row storage
    logic [btb_pkg::ROWS-1:0]   r_row_valid;
    logic [btb_pkg::TAG_W-1:0]  r_row_tag    [btb_pkg::ROWS];
    logic [31:0]                r_row_target [btb_pkg::ROWS];
    logic [btb_pkg::HIST_W-1:0] r_row_hist   [btb_pkg::ROWS];
    logic [btb_pkg::HIST_W-1:0] r_shared_hist;
    logic [31:0]                r_branches, r_flushes;

    // Effective settings
    logic [2:0]                 rl;
    logic [4:0]                 tag_cap, tb;
    logic [3:0]                 hb;
    logic [btb_pkg::ROW_W-1:0]  row_mask, row;
    logic [btb_pkg::TAG_W-1:0]  tag_mask, tag;
    logic [btb_pkg::HIST_W-1:0] hmask, hist, idx;
    logic [btb_pkg::SLOT_W-1:0] slot;
    logic                       hit, misaligned, local_table;

    always_comb begin
        rl       = (r_rows_log2 > 3'd5) ? 3'd5 : r_rows_log2;
        tag_cap  = 5'(6'd30 - {3'd0, rl});
        tb       = (r_tag_bits > tag_cap) ? tag_cap : r_tag_bits;
        hb       = (r_history_bits == 4'd0) ? 4'd1 :
                   (r_history_bits > 4'd8)  ? 4'd8 : r_history_bits;
        row_mask = btb_pkg::ROW_W'((6'd1 << rl) - 6'd1);
        row      = r_item.pc[btb_pkg::ROW_W+1:2] & row_mask;
        tag_mask = btb_pkg::TAG_W'((31'd1 << tb) - 31'd1);
        tag      = btb_pkg::TAG_W'(r_item.pc[31:2] >> rl) & tag_mask;
        hmask    = btb_pkg::HIST_W'((9'd1 << hb) - 9'd1);
        hist     = r_global_history ? r_shared_hist : r_row_hist[row];
        idx      = hist & hmask;
        if (r_global_table && r_share_mode == btb_pkg::SHARE_LOW) begin
            idx = idx ^ (r_item.pc[9:2] & hmask);
        end else if (r_global_table && r_share_mode == btb_pkg::SHARE_HIGH) begin
            idx = idx ^ (r_item.pc[23:16] & hmask);
        end
        slot        = r_global_table ? {{btb_pkg::ROW_W{1'b0}}, idx} : {row, idx};
        hit         = r_row_valid[row] && (r_row_tag[row] == tag);
        misaligned  = (r_item.pc[1:0] != 2'b00);
        local_table = !r_global_table;
    end

    // Counter memory, eight 2-bit counters a word
    logic [btb_pkg::WORD_W-1:0]  mem [btb_pkg::MDEPTH];
    logic [btb_pkg::WORD_W-1:0]  r_rdata, wdata, fill_init, fill_cfg;
    logic [btb_pkg::MADDR_W-1:0] waddr;
    logic [btb_pkg::LANE_W-1:0]  r_lane;
    logic                        we;
    logic [1:0]                  old_cnt, new_cnt;
    logic                        do_update, flush;

    assign fill_init = {btb_pkg::LANES{btb_pkg::COUNTER_RESET}};
    assign fill_cfg  = {btb_pkg::LANES{r_counter_init}};
    assign old_cnt   = r_rdata[2*r_lane +: 2];
    assign do_update = i_cmd.finish && !misaligned && (r_item.command == btb_pkg::CMD_UPDATE);
    assign flush     = (r_item.target_pc == r_item.predicted_target) ^ r_item.taken;

    // Saturating counter step
    always_comb begin
        new_cnt = old_cnt;
        if (r_item.taken) begin
            if (old_cnt != 2'd3) new_cnt = old_cnt + 2'd1;
        end else begin
            if (old_cnt != 2'd0) new_cnt = old_cnt - 2'd1;
        end
    end

    // Write port select
    always_comb begin
        we    = 1'b0;
        waddr = slot[btb_pkg::SLOT_W-1:btb_pkg::LANE_W];
        wdata = r_rdata;
        if (i_cmd.init_wr) begin
            we    = 1'b1;
            waddr = i_cmd.sweep;
            wdata = fill_init;
        end else if (i_cmd.clr_wr) begin
            we    = 1'b1;
            waddr = {row, i_cmd.sweep[btb_pkg::RWORD_W-1:0]};
            wdata = fill_cfg;
        end else if (do_update) begin
            we    = 1'b1;
            wdata[2*r_lane +: 2] = new_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[slot[btb_pkg::SLOT_W-1:btb_pkg::LANE_W]];
            r_lane  <= slot[btb_pkg::LANE_W-1:0];
        end
    end

    // Row, history and statistics update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid   <= '0;
            r_shared_hist <= '0;
            r_branches    <= '0;
            r_flushes     <= '0;
            for (int i = 0; i < btb_pkg::ROWS; i++) begin
                r_row_hist[i] <= '0;
            end
        end else begin
            if (i_cmd.alloc) begin
                r_row_valid[row]  <= 1'b1;
                r_row_tag[row]    <= tag;
                r_row_target[row] <= r_item.target_pc;
                if (!r_global_history) begin
                    r_row_hist[row] <= '0;
                end
            end
            if (do_update) begin
                if (r_global_history) begin
                    r_shared_hist <= {r_shared_hist[btb_pkg::HIST_W-2:0], r_item.taken};
                end else begin
                    r_row_hist[row] <= {r_row_hist[row][btb_pkg::HIST_W-2:0], r_item.taken};
                end
                r_branches <= r_branches + 32'd1;
                if (flush) begin
                    r_flushes <= r_flushes + 32'd1;
                end
            end
        end
    end

    // Result register
    btb_pkg::t_out_word r_out, n_out;
    logic               r_out_valid;
    logic               dir;

    always_comb begin
        dir                 = hit && (old_cnt >= 2'd2);
        n_out               = '0;
        n_out.branch_count  = r_branches;
        n_out.flush_count   = r_flushes;
        if (misaligned) begin
            n_out.misaligned = 1'b1;
        end else if (r_item.command == btb_pkg::CMD_PREDICT) begin
            n_out.predict_taken = dir;
            n_out.next_pc       = dir ? r_row_target[row] : r_item.pc + 32'd4;
        end else begin
            n_out.flush         = flush;
            n_out.branch_count  = r_branches + 32'd1;
            n_out.flush_count   = r_flushes + {31'd0, flush};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign o_stat.misaligned  = misaligned;
    assign o_stat.is_update   = (r_item.command == btb_pkg::CMD_UPDATE);
    assign o_stat.hit         = hit;
    assign o_stat.local_table = local_table;
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

endmodule

// ===== rtl/btb_two_level_branch_predictor_unit.sv =====
// Channel  | Direction | Handshake                | Payload
// input    | in        | i_in_valid / o_in_stall  | i_in_word (command, pc, targets, taken)
// result   | out       | o_out_valid / i_out_stall| o_out_word (prediction, flush, counts)
// config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One word is worked at a time: accept, row lookup with counter read, then
// counter update and result register. An update that misses allocates
// the row, then refills its counter table of 32 memory words when tables
// are per row (one memory word per cycle); the lookup then repeats.
// After reset all 1024 counter memory words are swept; input is stalled.
// The result register holds while stalled; the next word may be taken meanwhile.
module btb_two_level_branch_predictor_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  btb_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output btb_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    btb_pkg::t_ctl_cmd  cmd;
    btb_pkg::t_ctl_stat stat;
    logic               idle;

    btb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    btb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall  = !idle;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== tb/sv/tb_btb_two_level_branch_predictor_unit.sv =====
module tb_btb_two_level_branch_predictor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 60;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    btb_pkg::t_in_word  i_in_word = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    btb_pkg::t_out_word o_out_word;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    btb_two_level_branch_predictor_unit DUT (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [2:0]  m_rows_log2;
    logic [3:0]  m_hist_bits;
    logic [4:0]  m_tag_bits;
    logic [1:0]  m_ctr_init;
    logic        m_gl_hist;
    logic        m_gl_table;
    logic [1:0]  m_share;
    logic        m_valid [btb_pkg::ROWS];
    logic [29:0] m_tag [btb_pkg::ROWS];
    logic [31:0] m_target [btb_pkg::ROWS];
    logic [7:0]  m_hist [btb_pkg::ROWS];
    logic [7:0]  m_shared_hist;
    logic [1:0]  m_ctr [btb_pkg::ROWS*256];
    logic [31:0] m_branches;
    logic [31:0] m_flushes;

    btb_pkg::t_out_word expected_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_updates = 0;
    int          n_hits = 0;
    int          hold_req = 0;
    int          stall_left = 0;
    logic [31:0] pc_pool [16];

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch word %0d %s: got %h want %h", n_checked, what, got, want);
        errors++;
    endtask

    // counter table slot for a row and pc
    function automatic int ctr_slot(int row, logic [31:0] pc);
        int h;
        logic [7:0] hmask, idx;
        h = (m_hist_bits < 1) ? 1 : (m_hist_bits > 8 ? 8 : m_hist_bits);
        hmask = 8'((1 << h) - 1);
        idx = (m_gl_hist ? m_shared_hist : m_hist[row]) & hmask;
        if (m_gl_table) begin
            if (m_share == btb_pkg::SHARE_LOW) idx ^= pc[9:2] & hmask;
            else if (m_share == btb_pkg::SHARE_HIGH) idx ^= pc[23:16] & hmask;
            return idx;
        end
        return row * 256 + idx;
    endfunction

    // expected result for one word, advancing predictor state
    function automatic btb_pkg::t_out_word predict_branch(btb_pkg::t_in_word w);
        btb_pkg::t_out_word r;
        int rl, tb, row, slot;
        logic [31:0] tmask, tg;
        logic hit, fl;
        r = '0;
        rl = (m_rows_log2 > 5) ? 5 : m_rows_log2;
        tb = (m_tag_bits > 30 - rl) ? 30 - rl : m_tag_bits;
        row = (w.pc >> 2) & ((1 << rl) - 1);
        tmask = (32'd1 << tb) - 32'd1;
        tg = (w.pc >> (2 + rl)) & tmask;
        hit = m_valid[row] && (m_tag[row] == tg[29:0]);
        if (w.pc[1:0] != 2'b00) begin
            r.misaligned = 1'b1;
        end else if (w.command == btb_pkg::CMD_PREDICT) begin
            r.next_pc = w.pc + 32'd4;
            if (hit && m_ctr[ctr_slot(row, w.pc)] >= 2) begin
                r.predict_taken = 1'b1;
                r.next_pc = m_target[row];
            end
            if (hit) n_hits++;
        end else begin
            n_updates++;
            if (!hit) begin
                m_valid[row] = 1'b1;
                m_tag[row] = tg[29:0];
                m_target[row] = w.target_pc;
                if (!m_gl_hist) m_hist[row] = '0;
                if (!m_gl_table)
                    for (int i = 0; i < 256; i++) m_ctr[row*256 + i] = m_ctr_init;
            end
            slot = ctr_slot(row, w.pc);
            if (w.taken) begin
                if (m_ctr[slot] < 3) m_ctr[slot]++;
            end else begin
                if (m_ctr[slot] > 0) m_ctr[slot]--;
            end
            if (m_gl_hist) m_shared_hist = {m_shared_hist[6:0], w.taken};
            else m_hist[row] = {m_hist[row][6:0], w.taken};
            m_branches++;
            fl = (w.target_pc == w.predicted_target) ^ w.taken;
            if (fl) m_flushes++;
            r.flush = fl;
        end
        r.branch_count = m_branches;
        r.flush_count = m_flushes;
        return r;
    endfunction

    // send one word, then leave the input idle for the given gap
    task automatic send_word(btb_pkg::t_in_word w, int gap, output btb_pkg::t_out_word res);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        res = predict_branch(w);
        expected_q.push_back(res);
        n_sent++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // write all registers, one word per handshake
    task automatic write_settings(logic [2:0] rl, logic [3:0] hb, logic [4:0] tb,
                                  logic [1:0] ci, logic gh, logic gt, logic [1:0] sm);
        logic [2:0]  idx [7];
        logic [31:0] val [7];
        idx = '{btb_pkg::REG_ROWS_LOG2, btb_pkg::REG_HISTORY_BITS, btb_pkg::REG_TAG_BITS,
                btb_pkg::REG_COUNTER_INIT, btb_pkg::REG_GLOBAL_HISTORY,
                btb_pkg::REG_GLOBAL_TABLE, btb_pkg::REG_SHARE_MODE};
        val = '{32'(rl), 32'(hb), 32'(tb), 32'(ci), 32'(gh), 32'(gt), 32'(sm)};
        for (int i = 0; i < 7; i++) begin
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        m_rows_log2 = rl; m_hist_bits = hb; m_tag_bits = tb; m_ctr_init = ci;
        m_gl_hist = gh; m_gl_table = gt; m_share = sm;
    endtask

    function automatic btb_pkg::t_in_word make_word(logic cmd, logic [31:0] pc,
                                                    logic [31:0] tgt, logic tk,
                                                    logic [31:0] pred);
        btb_pkg::t_in_word w;
        w.command = cmd; w.pc = pc; w.target_pc = tgt; w.taken = tk;
        w.predicted_target = pred;
        return w;
    endfunction

    // extremes, misaligned pcs, allocate/train/hit and all flush cases
    task automatic test_directed();
        btb_pkg::t_out_word r;
        send_word(make_word(btb_pkg::CMD_PREDICT, 32'hFFFF_FFFC, '0, 1'b0, '0), 0, r);
        send_word(make_word(btb_pkg::CMD_PREDICT, 32'hFFFF_FFFF, '1, 1'b1, '1), 0, r);
        send_word(make_word(btb_pkg::CMD_UPDATE, 32'h0000_0001, '1, 1'b1, '1), 1, r);
        send_word(make_word(btb_pkg::CMD_UPDATE, 32'h0000_0002, '0, 1'b0, '0), 0, r);
        send_word(make_word(btb_pkg::CMD_PREDICT, 32'h0000_0000, '0, 1'b0, '0), 0, r);
        send_word(make_word(btb_pkg::CMD_UPDATE, 32'h0000_0000, 32'hFFFF_FFFC, 1'b1,
                            32'h4), 0, r);
        send_word(make_word(btb_pkg::CMD_PREDICT, 32'h0000_0000, '0, 1'b0, '0), 2, r);
        send_word(make_word(btb_pkg::CMD_UPDATE, 32'h0000_0000, 32'hFFFF_FFFC, 1'b1,
                            32'hFFFF_FFFC), 0, r);
        send_word(make_word(btb_pkg::CMD_PREDICT, 32'h0000_0000, '0, 1'b0, '0), 0, r);
        send_word(make_word(btb_pkg::CMD_UPDATE, 32'h0000_0080, 32'h1234_5678, 1'b0,
                            32'h1234_5678), 0, r);
        send_word(make_word(btb_pkg::CMD_UPDATE, 32'h0000_0080, 32'h1234_5678, 1'b0,
                            32'h84), 3, r);
        send_word(make_word(btb_pkg::CMD_PREDICT, 32'h0000_0080, '1, 1'b1, '1), 0, r);
        send_word(make_word(btb_pkg::CMD_UPDATE, 32'hFFFF_FFFC, '1, 1'b1, '0), 0, r);
        send_word(make_word(btb_pkg::CMD_UPDATE, 32'hFFFF_FFFC, '1, 1'b1, '1), 0, r);
        send_word(make_word(btb_pkg::CMD_PREDICT, 32'hFFFF_FFFC, '0, 1'b0, '0), 0, r);
        send_word(make_word(btb_pkg::CMD_PREDICT, 32'h0000_0003, '0, 1'b0, '0), 0, r);
        wait_idle();
    endtask

    // mostly predict-then-resolve pairs on a small set of branches, plus noise
    task automatic run_traffic(int n);
        btb_pkg::t_in_word w;
        btb_pkg::t_out_word r;
        logic [31:0] pc;
        int k;
        for (int i = 0; i < n; i++) begin
            pc = pc_pool[$urandom_range(0, 15)];
            k = $urandom_range(0, 99);
            if (k < 70) begin
                send_word(make_word(btb_pkg::CMD_PREDICT, pc, $urandom, 1'($urandom),
                                    $urandom), rand_gap(), r);
                w = make_word(btb_pkg::CMD_UPDATE, pc,
                              ($urandom_range(0, 3) == 0) ? $urandom : {pc[31:8], 8'h40},
                              $urandom_range(0, 3) != 0, r.next_pc);
                send_word(w, rand_gap(), r);
                i++;
            end else if (k < 85) begin
                w = make_word(1'($urandom), pc, $urandom, 1'($urandom), $urandom);
                send_word(w, rand_gap(), r);
            end else if (k < 95) begin
                w = make_word(1'($urandom), {$urandom} & 32'hFFFF_FFFC, $urandom,
                              1'($urandom), $urandom);
                send_word(w, rand_gap(), r);
            end else begin
                w = make_word(1'($urandom), $urandom | 32'h1, $urandom, 1'($urandom),
                              $urandom);
                send_word(w, rand_gap(), r);
            end
        end
        wait_idle();
    endtask

    task automatic new_pool();
        for (int i = 0; i < 16; i++) pc_pool[i] = {$urandom} & 32'hFFFF_FFFC;
        for (int i = 0; i < 4; i++) pc_pool[i][31:10] = pc_pool[4][31:10];
    endtask

    task automatic test_default_settings();
        new_pool();
        run_traffic(60);
    endtask

    // receiver holds off while input keeps coming, so the block backs up
    task automatic test_backpressure();
        new_pool();
        hold_req = 300;
        run_traffic(50);
    endtask

    task automatic test_settings_sweep();
        write_settings(3'd0, 4'd1, 5'd30, 2'd0, 1'b1, 1'b1, btb_pkg::SHARE_LOW);
        new_pool(); run_traffic(55);
        write_settings(3'd5, 4'd8, 5'd27, 2'd3, 1'b0, 1'b1, btb_pkg::SHARE_HIGH);
        new_pool(); run_traffic(55);
        write_settings(3'd7, 4'd0, 5'd31, 2'd2, 1'b1, 1'b0, 2'd3);
        new_pool(); run_traffic(55);
        write_settings(3'd3, 4'd15, 5'd10, 2'd1, 1'b1, 1'b1, btb_pkg::SHARE_HIGH);
        new_pool(); run_traffic(55);
        write_settings(3'd2, 4'd4, 5'd2, 2'd3, 1'b0, 1'b1, btb_pkg::SHARE_LOW);
        new_pool(); run_traffic(55);
        write_settings(3'd5, 4'd8, 5'd0, 2'd0, 1'b0, 1'b0, btb_pkg::SHARE_NONE);
        new_pool(); run_traffic(55);
    endtask

    // result stall: random short and long runs, plus requested hold-offs
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        btb_pkg::t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report("unexpected word", o_out_word.next_pc, '0);
            end else begin
                e = expected_q.pop_front();
                if (o_out_word.predict_taken !== e.predict_taken)
                    report("predict_taken", o_out_word.predict_taken, e.predict_taken);
                if (o_out_word.next_pc !== e.next_pc)
                    report("next_pc", o_out_word.next_pc, e.next_pc);
                if (o_out_word.flush !== e.flush)
                    report("flush", o_out_word.flush, e.flush);
                if (o_out_word.branch_count !== e.branch_count)
                    report("branch_count", o_out_word.branch_count, e.branch_count);
                if (o_out_word.flush_count !== e.flush_count)
                    report("flush_count", o_out_word.flush_count, e.flush_count);
                if (o_out_word.misaligned !== e.misaligned)
                    report("misaligned", o_out_word.misaligned, e.misaligned);
            end
            n_checked++;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        m_rows_log2 = 3'd5; m_hist_bits = 4'd2; m_tag_bits = 5'd0;
        m_ctr_init = btb_pkg::COUNTER_RESET; m_gl_hist = 1'b0; m_gl_table = 1'b0;
        m_share = btb_pkg::SHARE_NONE;
        for (int i = 0; i < btb_pkg::ROWS; i++) begin
            m_valid[i] = 1'b0; m_tag[i] = '0; m_target[i] = '0; m_hist[i] = '0;
        end
        for (int i = 0; i < btb_pkg::ROWS*256; i++) m_ctr[i] = btb_pkg::COUNTER_RESET;
        m_shared_hist = '0; m_branches = '0; m_flushes = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_default_settings();
        test_backpressure();
        test_settings_sweep();

        $display("covered %0d words (%0d updates, %0d predict hits), %0d results checked",
                 n_sent, n_updates, n_hits, n_checked);
        $display("seven register settings including out-of-range values, long hold-off");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_q.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
